[rtl/bpc_pkg.sv]
// Package for the byte predicated core step block: codes, field layouts,
// state enum and address helpers. Depends on nothing; all rtl files import it.
package bpc_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int NUM_REGS      = 4;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 32;

    typedef logic [MEM_ADDR_BITS-1:0] mem_addr_t;

    // operations
    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_JUMP  = 2'd1;
    localparam logic [1:0] OP_CMP   = 2'd2;
    localparam logic [1:0] OP_MEMWR = 2'd3;

    // move kinds
    localparam logic [2:0] MV_REG  = 3'd0;
    localparam logic [2:0] MV_IMM  = 3'd1;
    localparam logic [2:0] MV_LOAD = 3'd2;

    // jump conditions
    localparam logic [2:0] JMP_ALWAYS   = 3'd0;
    localparam logic [2:0] JMP_IF_TRUE  = 3'd1;
    localparam logic [2:0] JMP_IF_FALSE = 3'd2;

    // compare relations
    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_GT = 3'd3;
    localparam logic [2:0] CMP_LE = 3'd4;
    localparam logic [2:0] CMP_GE = 3'd5;

    // predicate combine modes
    localparam logic [1:0] CMB_SET = 2'd0;
    localparam logic [1:0] CMB_AND = 2'd1;
    localparam logic [1:0] CMB_OR  = 2'd2;
    localparam logic [1:0] CMB_XOR = 2'd3;

    // error codes
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_BAD_REG     = 3'd1;
    localparam logic [2:0] ERR_BAD_MOVE    = 3'd2;
    localparam logic [2:0] ERR_BAD_JUMP    = 3'd3;
    localparam logic [2:0] ERR_BAD_CMP     = 3'd4;
    localparam logic [2:0] ERR_BAD_COMBINE = 3'd5;

    // input beat, last field in the lowest bits
    typedef struct packed {
        logic [15:0] load_address;
        logic        jump_uses_immediate;
        logic        short_jump;
        logic [7:0]  immediate;
        logic [3:0]  src_b_reg;
        logic [3:0]  src_a_reg;
        logic [3:0]  dest_reg;
        logic [1:0]  combine_mode;
        logic [2:0]  sub_op;
        logic [1:0]  operation;
    } item_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [7:0]  written_value;
        logic        predicate;
        logic [15:0] program_counter;
    } result_t;

    localparam int OUT_PAD = OUT_TDATA_W - $bits(result_t);

    // everything the execute step decides for one item
    typedef struct packed {
        logic        reg_we;
        logic [1:0]  reg_idx;
        logic [7:0]  reg_data;
        logic        mem_we;
        mem_addr_t   mem_addr;
        logic [7:0]  mem_data;
        logic [15:0] pc_next;
        logic        pred_next;
        result_t     res;
    } exec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_X,
        ST_RD_Y,
        ST_RD_M,
        ST_EXEC
    } state_t;

    function automatic mem_addr_t reg_addr(input logic [7:0] v);
        logic [15:0] wide;
        wide = {8'h00, v};
        return wide[MEM_ADDR_BITS-1:0];
    endfunction

    function automatic mem_addr_t pair_addr(input logic [15:0] v);
        return v[MEM_ADDR_BITS-1:0];
    endfunction

endpackage

[rtl/bpc_exec.sv]
// Execute step: error checks, move value, jump target, compare and
// predicate combine for one item. Depends on bpc_pkg.
module bpc_exec
(
    input  bpc_pkg::item_t item,
    input  logic [7:0]     x_val,
    input  logic [7:0]     y_val,
    input  logic [7:0]     m_val,
    input  logic [7:0]     d_base,
    input  logic [15:0]    pc,
    input  logic           pred,
    output bpc_pkg::exec_t ex
);
    import bpc_pkg::*;

    always_comb
    begin
        logic        take;
        logic        cmp_r;
        logic [7:0]  mv_val;
        logic [7:0]  off;
        logic [2:0]  err;
        logic [7:0]  wv;

        take   = 1'b0;
        cmp_r  = 1'b0;
        mv_val = 8'h00;
        off    = 8'h00;
        err    = ERR_OK;
        wv     = 8'h00;

        ex           = '0;
        ex.pc_next   = pc;
        ex.pred_next = pred;
        ex.mem_addr  = pair_addr(item.load_address);

        unique case (item.operation)
            OP_MOVE:
            begin
                if (item.sub_op > MV_LOAD)
                begin
                    err = ERR_BAD_MOVE;
                end
                else if (item.dest_reg[3]
                         || (item.sub_op != MV_IMM && item.src_a_reg[3])
                         || (item.sub_op == MV_LOAD && item.src_b_reg[3]))
                begin
                    err = ERR_BAD_REG;
                end
                else
                begin
                    priority if (item.sub_op == MV_REG)
                        mv_val = y_val;
                    else if (item.sub_op == MV_IMM)
                        mv_val = item.immediate;
                    else
                        mv_val = m_val;
                    // indexes 4 to 7 store through the base register
                    if (item.dest_reg[2])
                    begin
                        ex.mem_we   = 1'b1;
                        ex.mem_addr = reg_addr(d_base);
                        ex.mem_data = mv_val;
                    end
                    else
                    begin
                        ex.reg_we   = 1'b1;
                        ex.reg_idx  = item.dest_reg[1:0];
                        ex.reg_data = mv_val;
                    end
                    wv = mv_val;
                end
            end
            OP_JUMP:
            begin
                if (item.sub_op > JMP_IF_FALSE)
                begin
                    err = ERR_BAD_JUMP;
                end
                else
                begin
                    take = (item.sub_op == JMP_ALWAYS)
                        || (item.sub_op == JMP_IF_TRUE && pred)
                        || (item.sub_op == JMP_IF_FALSE && !pred);
                    if (take)
                    begin
                        if (item.short_jump)
                        begin
                            if (!item.jump_uses_immediate && item.src_a_reg[3])
                                err = ERR_BAD_REG;
                            else
                            begin
                                off = item.jump_uses_immediate ? item.immediate : y_val;
                                ex.pc_next = pc + {{8{off[7]}}, off};
                            end
                        end
                        else if (item.dest_reg[3] || item.src_a_reg[3])
                            err = ERR_BAD_REG;
                        else
                            ex.pc_next = {x_val, y_val};
                    end
                end
            end
            OP_CMP:
            begin
                if (item.sub_op > CMP_GE)
                begin
                    err = ERR_BAD_CMP;
                end
                else if (item.dest_reg[3] || item.src_a_reg[3])
                begin
                    err = ERR_BAD_REG;
                end
                else
                begin
                    unique case (item.sub_op)
                        CMP_EQ:  cmp_r = (x_val == y_val);
                        CMP_NE:  cmp_r = (x_val != y_val);
                        CMP_LT:  cmp_r = (x_val <  y_val);
                        CMP_GT:  cmp_r = (x_val >  y_val);
                        CMP_LE:  cmp_r = (x_val <= y_val);
                        default: cmp_r = (x_val >= y_val);
                    endcase
                    unique case (item.combine_mode)
                        CMB_SET: ex.pred_next = cmp_r;
                        CMB_AND: ex.pred_next = pred & cmp_r;
                        CMB_OR:  ex.pred_next = pred | cmp_r;
                        CMB_XOR: ex.pred_next = pred ^ cmp_r;
                    endcase
                end
            end
            OP_MEMWR:
            begin
                ex.mem_we   = 1'b1;
                ex.mem_addr = pair_addr(item.load_address);
                ex.mem_data = item.immediate;
            end
        endcase

        ex.res.program_counter = ex.pc_next;
        ex.res.predicate       = ex.pred_next;
        ex.res.written_value   = wv;
        ex.res.error_code      = err;
    end

endmodule

[rtl/byte_predicated_core_step_core.sv]
// Top level of the byte predicated core step block: input buffer, read
// sequencer, data memory, register file and result register.
// Depends on bpc_pkg and bpc_exec.

// Each input beat is one decoded instruction for a small 8-bit core with four
// byte registers (indexes 4 to 7 reach memory through register index mod 4),
// a byte data memory, a 16-bit PC and a predicate bit. Each instruction gives
// exactly one output beat: PC and predicate after it, the byte a move stored
// (else zero) and an error code; an errored instruction changes no state.
// Every instruction runs three read slots on the single-port data memory
// (first operand, second operand, loaded byte) and one execute slot that
// writes the register file or the memory. A one-beat input buffer takes
// the next instruction while the current one runs, and a result register holds
// the finished beat for the sink; execution holds in its last slot only while
// the previous result is still waiting downstream. Memory contents are
// undefined until written; there is no clearing pass.
module byte_predicated_core_step_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation, sub_op, combine_mode, dest_reg, src_a_reg, src_b_reg,
    // immediate, short_jump, jump_uses_immediate, load_address, zero pad
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // program_counter, predicate, written_value, error_code, zero pad
    output logic [31:0] m_axis_tdata
);
    import bpc_pkg::*;

    state_t      state_reg;
    state_t      state_next;

    logic        buf_valid_reg;
    item_t       buf_item_reg;
    item_t       cur_item_reg;

    logic [7:0]  regs_reg [NUM_REGS];
    logic [15:0] pc_reg;
    logic        pred_reg;

    logic [7:0]  x_val_reg;
    logic [7:0]  y_val_reg;

    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  mem_q_reg;
    logic        mem_rd;
    logic        mem_wr;
    mem_addr_t   mem_addr;
    logic [7:0]  mem_wdata;

    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        accept;
    logic        out_free;
    logic        commit;
    logic        load_cur;
    logic [3:0]  x_idx;
    logic [7:0]  x_now;
    logic [7:0]  y_now;
    exec_t       ex;

    assign s_axis_tready = !buf_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign commit        = (state_reg == ST_EXEC) && out_free;
    assign load_cur      = buf_valid_reg && ((state_reg == ST_IDLE) || commit);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_res_reg};

    // first operand: high address byte for a load, else dest_reg
    assign x_idx = (cur_item_reg.operation == OP_MOVE && cur_item_reg.sub_op == MV_LOAD)
                 ? cur_item_reg.src_b_reg : cur_item_reg.dest_reg;

    // operand is either the direct register or the byte just read back
    assign x_now = x_idx[2] ? mem_q_reg : regs_reg[x_idx[1:0]];
    assign y_now = cur_item_reg.src_a_reg[2] ? mem_q_reg
                 : regs_reg[cur_item_reg.src_a_reg[1:0]];

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (buf_valid_reg) state_next = ST_RD_X;
            ST_RD_X: state_next = ST_RD_Y;
            ST_RD_Y: state_next = ST_RD_M;
            ST_RD_M: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (out_free)
                    state_next = buf_valid_reg ? ST_RD_X : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port: one read a cycle during operand fetch, write on commit
    always_comb
    begin
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        mem_addr  = ex.mem_addr;
        mem_wdata = ex.mem_data;
        unique case (state_reg)
            ST_RD_X:
            begin
                mem_rd   = 1'b1;
                mem_addr = reg_addr(regs_reg[x_idx[1:0]]);
            end
            ST_RD_Y:
            begin
                mem_rd   = 1'b1;
                mem_addr = reg_addr(regs_reg[cur_item_reg.src_a_reg[1:0]]);
            end
            ST_RD_M:
            begin
                mem_rd   = 1'b1;
                mem_addr = pair_addr({x_val_reg, y_now});
            end
            ST_EXEC:
            begin
                mem_wr = commit && ex.mem_we;
            end
            default:
            begin
                mem_rd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------
    // input buffer and current item
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_valid_reg <= 1'b0;
        else if (accept)
            buf_valid_reg <= 1'b1;
        else if (load_cur)
            buf_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_item_reg <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
        if (load_cur)
            cur_item_reg <= buf_item_reg;
        // latch operands as they come back from memory
        if (state_reg == ST_RD_Y)
            x_val_reg <= x_now;
        if (state_reg == ST_RD_M)
            y_val_reg <= y_now;
    end

    // ---------------------------------------------------------------
    // data memory, single port, registered read
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[mem_addr] <= mem_wdata;
        if (mem_rd)
            mem_q_reg <= mem[mem_addr];
    end

    // ---------------------------------------------------------------
    // execute
    // ---------------------------------------------------------------
    bpc_exec u_exec
    (
        .item   (cur_item_reg),
        .x_val  (x_val_reg),
        .y_val  (y_val_reg),
        .m_val  (mem_q_reg),
        .d_base (regs_reg[cur_item_reg.dest_reg[1:0]]),
        .pc     (pc_reg),
        .pred   (pred_reg),
        .ex     (ex)
    );

    // architectural state advances only when the result can be handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= 8'h00;
            pc_reg   <= 16'h0000;
            pred_reg <= 1'b0;
        end
        else if (commit)
        begin
            if (ex.reg_we)
                regs_reg[ex.reg_idx] <= ex.reg_data;
            pc_reg   <= ex.pc_next;
            pred_reg <= ex.pred_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_res_reg <= ex.res;
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_wr_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (state_reg == ST_EXEC) && !mem_rd)
        else $error("memory write outside execute slot");

    a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_X) |=> (state_reg == ST_RD_Y))
        else $error("operand fetch sequence broken");

    a_err_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (ex.res.error_code != ERR_OK)
        |=> (pc_reg == $past(pc_reg)) && (pred_reg == $past(pred_reg)))
        else $error("errored instruction changed PC or predicate");

    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (ex.res.error_code != ERR_OK)
        |-> !ex.reg_we && !ex.mem_we && (ex.res.written_value == 8'h00))
        else $error("errored instruction wrote state");

    a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("completed instruction gave no result beat");

endmodule

[verif/byte_predicated_core_step_core_tb.sv]
// Self-checking testbench for byte_predicated_core_step_core: directed table, then random
// instruction streams checked beat by beat against an in-bench model of the core state.
// Depends on bpc_pkg and the rtl of the block; needs no files or arguments.
module byte_predicated_core_step_core_tb;

    import bpc_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 16;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        item_t   instr;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    // shadow of the core state, advanced once per accepted input beat
    logic [7:0]  core_regs [0:NUM_REGS-1];
    logic [7:0]  core_mem [0:MEM_DEPTH-1];
    bit          byte_written [0:MEM_DEPTH-1];
    logic [15:0] core_pc;
    logic        core_pred;

    result_t     pending_results [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count;
    int          cycle_count = 0;
    int          tx_burst_pct;
    bit          calm;

    byte_predicated_core_step_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Core model
    // ------------------------------------------------------------------

    function automatic bit jump_taken(input logic [2:0] cond);
        return (cond == JMP_ALWAYS) || (cond == JMP_IF_TRUE && core_pred) ||
               (cond == JMP_IF_FALSE && !core_pred);
    endfunction

    // Indexes 0..3 name a register, 4..7 the memory byte that register (index mod 4)
    // points at. Callers guarantee the index is below 8.
    function automatic logic [7:0] fetch_operand(input logic [3:0] idx);
        if (idx[2])
            return core_mem[mem_addr_t'(core_regs[idx[1:0]])];
        return core_regs[idx[1:0]];
    endfunction

    function automatic void store_operand(input logic [3:0] idx, input logic [7:0] v);
        mem_addr_t addr;
        addr = mem_addr_t'(core_regs[idx[1:0]]);
        if (idx[2])
        begin
            core_mem[addr]     = v;
            byte_written[addr] = 1'b1;
        end
        else
            core_regs[idx[1:0]] = v;
    endfunction

    // Error code of an instruction in the current state. Sub-op checks win over the
    // register check; an untaken jump reads nothing and so never faults on a register.
    function automatic logic [2:0] decode_error(input item_t it);
        bit d_bad;
        bit a_bad;
        bit b_bad;
        d_bad = it.dest_reg[3];
        a_bad = it.src_a_reg[3];
        b_bad = it.src_b_reg[3];
        case (it.operation)
            OP_MOVE:
            begin
                if (it.sub_op > MV_LOAD)
                    return ERR_BAD_MOVE;
                if (d_bad || (it.sub_op != MV_IMM && a_bad) || (it.sub_op == MV_LOAD && b_bad))
                    return ERR_BAD_REG;
            end
            OP_JUMP:
            begin
                if (it.sub_op > JMP_IF_FALSE)
                    return ERR_BAD_JUMP;
                if (jump_taken(it.sub_op))
                begin
                    if (it.short_jump && !it.jump_uses_immediate && a_bad)
                        return ERR_BAD_REG;
                    if (!it.short_jump && (d_bad || a_bad))
                        return ERR_BAD_REG;
                end
            end
            OP_CMP:
            begin
                if (it.sub_op > CMP_GE)
                    return ERR_BAD_CMP;
                if (d_bad || a_bad)
                    return ERR_BAD_REG;
            end
            default: ;
        endcase
        return ERR_OK;
    endfunction

    // Address of a never-written byte that reading this operand would touch, else -1.
    function automatic int operand_hole(input logic [3:0] idx);
        mem_addr_t addr;
        addr = mem_addr_t'(core_regs[idx[1:0]]);
        if (idx[2] && !byte_written[addr])
            return int'(addr);
        return -1;
    endfunction

    // First never-written byte the instruction would read, else -1. Keep the stream
    // clear of such reads: fill the hole first, then retry.
    function automatic int first_missing_byte(input item_t it);
        int        hole;
        mem_addr_t addr;
        hole = -1;
        if (decode_error(it) != ERR_OK)
            return -1;
        case (it.operation)
            OP_MOVE:
            begin
                if (it.sub_op == MV_REG)
                    hole = operand_hole(it.src_a_reg);
                else if (it.sub_op == MV_LOAD)
                begin
                    hole = operand_hole(it.src_b_reg);
                    if (hole < 0)
                        hole = operand_hole(it.src_a_reg);
                    if (hole < 0)
                    begin
                        addr = mem_addr_t'({fetch_operand(it.src_b_reg),
                                            fetch_operand(it.src_a_reg)});
                        if (!byte_written[addr])
                            hole = int'(addr);
                    end
                end
            end
            OP_JUMP:
            begin
                if (jump_taken(it.sub_op))
                begin
                    if (!it.short_jump)
                        hole = operand_hole(it.dest_reg);
                    if (hole < 0 && !(it.short_jump && it.jump_uses_immediate))
                        hole = operand_hole(it.src_a_reg);
                end
            end
            OP_CMP:
            begin
                hole = operand_hole(it.dest_reg);
                if (hole < 0)
                    hole = operand_hole(it.src_a_reg);
            end
            default: ;
        endcase
        return hole;
    endfunction

    // Run one instruction on the shadow state and return the beat it should produce.
    function automatic result_t execute_instr(input item_t it);
        result_t     r;
        logic [2:0]  err;
        logic [7:0]  wv;
        logic [7:0]  v;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  off;
        logic        rel;
        err = decode_error(it);
        wv  = 8'h00;
        if (err == ERR_OK)
        begin
            case (it.operation)
                OP_MOVE:
                begin
                    if (it.sub_op == MV_REG)
                        v = fetch_operand(it.src_a_reg);
                    else if (it.sub_op == MV_IMM)
                        v = it.immediate;
                    else
                        v = core_mem[mem_addr_t'({fetch_operand(it.src_b_reg),
                                                  fetch_operand(it.src_a_reg)})];
                    // sources are all read before an indirect destination is written
                    store_operand(it.dest_reg, v);
                    wv = v;
                end
                OP_JUMP:
                begin
                    if (jump_taken(it.sub_op))
                    begin
                        if (it.short_jump)
                        begin
                            off = it.jump_uses_immediate ? it.immediate
                                                         : fetch_operand(it.src_a_reg);
                            core_pc = core_pc + {{8{off[7]}}, off};
                        end
                        else
                            core_pc = {fetch_operand(it.dest_reg), fetch_operand(it.src_a_reg)};
                    end
                end
                OP_CMP:
                begin
                    x = fetch_operand(it.dest_reg);
                    y = fetch_operand(it.src_a_reg);
                    case (it.sub_op)
                        CMP_EQ:  rel = (x == y);
                        CMP_NE:  rel = (x != y);
                        CMP_LT:  rel = (x < y);
                        CMP_GT:  rel = (x > y);
                        CMP_LE:  rel = (x <= y);
                        default: rel = (x >= y);
                    endcase
                    case (it.combine_mode)
                        CMB_SET: core_pred = rel;
                        CMB_AND: core_pred = core_pred & rel;
                        CMB_OR:  core_pred = core_pred | rel;
                        default: core_pred = core_pred ^ rel;
                    endcase
                end
                default:
                begin
                    core_mem[mem_addr_t'(it.load_address)]     = it.immediate;
                    byte_written[mem_addr_t'(it.load_address)] = 1'b1;
                end
            endcase
        end
        r.program_counter = core_pc;
        r.predicate       = core_pred;
        r.written_value   = wv;
        r.error_code      = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t make_instr(input logic [1:0] op, input logic [2:0] sub,
                                         input logic [1:0] comb, input logic [3:0] d,
                                         input logic [3:0] a, input logic [3:0] b,
                                         input logic [7:0] imm, input logic sj,
                                         input logic ji, input logic [15:0] la);
        item_t it;
        it.operation           = op;
        it.sub_op              = sub;
        it.combine_mode        = comb;
        it.dest_reg            = d;
        it.src_a_reg           = a;
        it.src_b_reg           = b;
        it.immediate           = imm;
        it.short_jump          = sj;
        it.jump_uses_immediate = ji;
        it.load_address        = la;
        return it;
    endfunction

    function automatic void add_row(input item_t it, input bit typed, input logic [15:0] pc,
                                    input logic pred, input logic [7:0] wv,
                                    input logic [2:0] err);
        stim_row_t row;
        row.instr                = it;
        row.typed                = typed;
        row.want.program_counter = pc;
        row.want.predicate       = pred;
        row.want.written_value   = wv;
        row.want.error_code      = err;
        directed_rows.push_back(row);
    endfunction

    // mostly legal register indexes, now and then one of 8..15
    function automatic logic [3:0] pick_reg();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(8, 15));
        return 4'($urandom_range(0, 7));
    endfunction

    function automatic item_t random_instr();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        it.operation = (pick < 35) ? OP_MOVE : (pick < 55) ? OP_JUMP :
                       (pick < 80) ? OP_CMP : OP_MEMWR;
        case (it.operation)
            OP_MOVE: it.sub_op = 3'($urandom_range(0, MV_LOAD));
            OP_JUMP: it.sub_op = 3'($urandom_range(0, JMP_IF_FALSE));
            OP_CMP:  it.sub_op = 3'($urandom_range(0, CMP_GE));
            default: it.sub_op = 3'($urandom_range(0, 7));
        endcase
        // now and then an illegal sub-op
        if ($urandom_range(0, 19) == 0)
            it.sub_op = 3'($urandom_range(0, 7));
        it.combine_mode = 2'($urandom_range(0, 3));
        it.dest_reg     = pick_reg();
        it.src_a_reg    = pick_reg();
        it.src_b_reg    = pick_reg();
        // favor corner bytes so equal compares and sign edges come up often
        case ($urandom_range(0, 9))
            0:       it.immediate = 8'h00;
            1:       it.immediate = 8'hFF;
            2:       it.immediate = 8'h80;
            3:       it.immediate = 8'h7F;
            default: it.immediate = 8'($urandom_range(0, 255));
        endcase
        it.short_jump          = 1'($urandom_range(0, 1));
        it.jump_uses_immediate = 1'($urandom_range(0, 1));
        // aim memory writes where indirect operands and loads will look
        case ($urandom_range(0, 3))
            0:       it.load_address = {8'h00, core_regs[$urandom_range(0, 3)]};
            1:       it.load_address = {core_regs[$urandom_range(0, 3)],
                                        core_regs[$urandom_range(0, 3)]};
            default: it.load_address = 16'($urandom_range(0, 65535));
        endcase
        return it;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Present one beat, hold it until accepted, then advance the model.
    task automatic issue(input item_t it, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < tx_burst_pct)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= 48'(it);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = execute_instr(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold off until every outstanding beat has come back.
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sink side: random backpressure bursts, with quiet stretches
    // ------------------------------------------------------------------

    initial
    begin
        int burst;
        int rx_burst_pct;
        int phase;
        m_axis_tready = 1'b0;
        burst         = 0;
        rx_burst_pct  = 20;
        phase         = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (phase % 128 == 0)
                rx_burst_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            if (burst == 0 && !calm && $urandom_range(0, 99) < rx_burst_pct)
                burst = $urandom_range(1, 4);
            if (burst > 0)
            begin
                m_axis_tready <= 1'b0;
                burst--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every output beat with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0)
                log_mismatch("unexpected output beat", int'(m_axis_tdata), 0);
            else
            begin
                want = pending_results.pop_front();
                if (seen.program_counter != want.program_counter)
                    log_mismatch("program_counter", seen.program_counter,
                                 want.program_counter);
                if (seen.predicate != want.predicate)
                    log_mismatch("predicate", seen.predicate, want.predicate);
                if (seen.written_value != want.written_value)
                    log_mismatch("written_value", seen.written_value, want.written_value);
                if (seen.error_code != want.error_code)
                    log_mismatch("error_code", seen.error_code, want.error_code);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int    n;
        int    hole;
        int    drain_wait;
        item_t cand;
        item_t fill;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        mismatch_count = 0;
        tx_burst_pct   = 20;
        calm           = 1'b0;
        core_pc        = 16'h0000;
        core_pred      = 1'b0;
        for (n = 0; n < NUM_REGS; n++)
            core_regs[n] = 8'h00;

        // Directed table. Typed rows are read straight off the spec; the rest go
        // through the model. Memory is only read where a row above wrote it.
        //            op         sub           comb     d      a      b      imm    sj ji la
        add_row(make_instr(OP_MOVE, MV_IMM, CMB_SET, 4'd0, 4'd0, 4'd0, 8'hFF, 0, 0, 16'h0000),
                1, 16'h0000, 0, 8'hFF, ERR_OK);
        // unused fields at their extremes must not matter
        add_row(make_instr(OP_MOVE, MV_IMM, CMB_XOR, 4'd1, 4'd15, 4'd15, 8'h00, 1, 1, 16'hFFFF),
                1, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_MOVE, 3'd7, CMB_SET, 4'd0, 4'd0, 4'd0, 8'h12, 0, 0, 16'h0000),
                1, 16'h0000, 0, 8'h00, ERR_BAD_MOVE);
        add_row(make_instr(OP_JUMP, 3'd7, CMB_SET, 4'd0, 4'd0, 4'd0, 8'h12, 1, 1, 16'h0000),
                1, 16'h0000, 0, 8'h00, ERR_BAD_JUMP);
        // bad relation is reported ahead of the bad register
        add_row(make_instr(OP_CMP, 3'd6, CMB_SET, 4'd15, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                1, 16'h0000, 0, 8'h00, ERR_BAD_CMP);
        add_row(make_instr(OP_MOVE, MV_REG, CMB_SET, 4'd15, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                1, 16'h0000, 0, 8'h00, ERR_BAD_REG);
        add_row(make_instr(OP_CMP, CMP_EQ, CMB_SET, 4'd0, 4'd8, 4'd0, 8'h00, 0, 0, 16'h0000),
                1, 16'h0000, 0, 8'h00, ERR_BAD_REG);
        add_row(make_instr(OP_MEMWR, 3'd7, CMB_XOR, 4'd15, 4'd15, 4'd15, 8'hA5, 1, 1, 16'hFFFF),
                1, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_MEMWR, 3'd0, CMB_SET, 4'd0, 4'd0, 4'd0, 8'h5A, 0, 0, 16'h0000),
                1, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_MOVE, MV_IMM, CMB_SET, 4'd2, 4'd0, 4'd0, 8'hFF, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        // load from the top address built from two registers
        add_row(make_instr(OP_MOVE, MV_LOAD, CMB_SET, 4'd1, 4'd2, 4'd2, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        // indirect destination, then indirect source of the same byte
        add_row(make_instr(OP_MOVE, MV_REG, CMB_SET, 4'd4, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_MOVE, MV_REG, CMB_SET, 4'd1, 4'd4, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_CMP, CMP_EQ, CMB_SET, 4'd0, 4'd2, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        // untaken jump with illegal registers must not fault
        add_row(make_instr(OP_JUMP, JMP_IF_FALSE, CMB_SET, 4'd15, 4'd15, 4'd0, 8'h00, 0, 0,
                           16'h0000), 0, 16'h0000, 0, 8'h00, ERR_OK);
        // short jumps: most negative offset, most positive, register offset, wrap
        add_row(make_instr(OP_JUMP, JMP_IF_TRUE, CMB_SET, 4'd0, 4'd0, 4'd0, 8'h80, 1, 1, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_JUMP, JMP_ALWAYS, CMB_SET, 4'd0, 4'd0, 4'd0, 8'h7F, 1, 1, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_JUMP, JMP_ALWAYS, CMB_SET, 4'd0, 4'd1, 4'd0, 8'h00, 1, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_JUMP, JMP_ALWAYS, CMB_SET, 4'd0, 4'd0, 4'd0, 8'h03, 1, 1, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_JUMP, JMP_ALWAYS, CMB_SET, 4'd0, 4'd1, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_JUMP, JMP_ALWAYS, CMB_SET, 4'd8, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_JUMP, JMP_ALWAYS, CMB_SET, 4'd0, 4'd9, 4'd0, 8'h00, 1, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        // combine modes on top of the predicate set above
        add_row(make_instr(OP_CMP, CMP_LT, CMB_AND, 4'd1, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_CMP, CMP_GE, CMB_OR, 4'd1, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);
        add_row(make_instr(OP_CMP, CMP_GT, CMB_XOR, 4'd1, 4'd0, 4'd0, 8'h00, 0, 0, 16'h0000),
                0, 16'h0000, 0, 8'h00, ERR_OK);

        // hold reset, then release it on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].instr, directed_rows[i].typed, directed_rows[i].want);
        wait_for_results();

        // Random part. Before any instruction that would read a never-written byte,
        // write that byte first; this keeps indirect operands and loads live.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                tx_burst_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if (n == RANDOM_ITEMS / 2)
                wait_for_results();
            cand = random_instr();
            hole = first_missing_byte(cand);
            while (hole >= 0)
            begin
                fill              = random_instr();
                fill.operation    = OP_MEMWR;
                fill.load_address = 16'(hole);
                issue(fill, 1'b0, result_t'(0));
                hole = first_missing_byte(cand);
            end
            issue(cand, 1'b0, result_t'(0));
        end

        // drain, then let the bench settle to catch stray beats
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            log_mismatch("output beats never delivered", 0, pending_results.size());

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
